// ===== src/aob_pkg.sv =====
//==============================================================================
// aob_pkg
// Shared types, register codes and the quarter-wave sine function.
//==============================================================================
package aob_pkg;

    typedef enum logic [1:0] {
        REG_BASE_INC  = 2'd0,
        REG_CYCLE_LEN = 2'd1,
        REG_SHAPE     = 2'd2,
        REG_OSC_COUNT = 2'd3
    } t_reg_index;

    typedef enum logic [2:0] {
        SHAPE_SINE     = 3'd0,
        SHAPE_SAW      = 3'd1,
        SHAPE_SQUARE   = 3'd2,
        SHAPE_TRIANGLE = 3'd3,
        SHAPE_PULSE    = 3'd4,
        SHAPE_NOISE    = 3'd5
    } t_shape;

    typedef enum logic {
        OP_AUDIO = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_op                operation;
        logic signed [15:0] audio_in;
        logic [4:0]         osc_index;
        logic [15:0]        osc_gain;
        logic [15:0]        osc_phase;
        logic [15:0]        osc_freq_factor;
    } t_in_item;

    typedef struct packed {
        t_reg_index  index;
        logic [31:0] value;
    } t_cfg_item;

    typedef logic signed [15:0] t_sample;

    localparam int          SINE_TABLE_DEPTH = 256;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam logic [31:0] BASE_INC_RESET = 32'd39370534;
    localparam logic [19:0] CYCLE_LEN_RESET = 20'd48000;
    localparam logic [15:0] FREQ_ONE = 16'd256;
    localparam logic [15:0] GAIN_FULL = 16'hFFFF;

    // Quarter sine magnitude for entry k of the table, from a Q30 Taylor series
    // rounded to 32767 full scale.
    function automatic logic [15:0] quarter_sine(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        x = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
        x2 = (x * x) >> 30;
        term = x;
        acc = $signed(x);
        for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n[0]) acc = acc - $signed(term);
            else acc = acc + $signed(term);
        end
        if (acc < 0) acc = '0;
        return 16'(((64'(acc) * 64'd32767) + (64'd1 << 29)) >> 30);
    endfunction

endpackage

// ===== src/aob_if.sv =====
//==============================================================================
// aob_stream_if
// Valid/ready channel carrying a generic payload.
//==============================================================================
interface aob_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/additive_oscillator_bank_unit.sv =====
//==============================================================================
// additive_oscillator_bank_unit
// Oscillator bank: table writes and audio samples on one input channel.
//==============================================================================
// A table write completes on its transfer. An audio sample goes through a setup step,
// one table read per active oscillator into a three-stage pipeline, leaving the scan,
// draining the pipeline and the divider before it reaches the output register.
// The next item is taken while a result waits in the output register.
// Reset (synchronous, active low) restores the registers and the table.
module additive_oscillator_bank_unit
    import aob_pkg::*;
#(
    parameter int MAX_OSCILLATORS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    aob_stream_if.sink   i_in,
    aob_stream_if.sink   i_cfg,
    aob_stream_if.source o_out
);
    localparam int IW = (MAX_OSCILLATORS > 1) ? $clog2(MAX_OSCILLATORS) : 1;
    localparam int SW = $clog2(SINE_TABLE_DEPTH);

    logic [31:0] r_base_inc;
    logic [19:0] r_cycle_len;
    logic [2:0]  r_shape;
    logic [5:0]  r_osc_count;

    // Table entry: gain, phase, frequency factor.
    logic [47:0] r_mem [MAX_OSCILLATORS];
    logic [47:0] r_rd;
    logic [MAX_OSCILLATORS-1:0] r_written;
    logic        r_rd_vld;
    logic [IW-1:0] r_rd_idx;

    t_state r_state, n_state;
    logic [6:0]  r_idx;
    logic [6:0]  w_count;
    logic [19:0] r_time;
    logic [15:0] r_lfsr;
    logic [15:0] r_audio;
    logic [21:0] r_gain_tot;
    logic [54:0] r_acc;
    logic [51:0] r_tb;
    logic        r_tb_vld;

    // Stage 1 (entry read) -> stage 2 (phase) -> stage 3 (wave, accumulate).
    logic        r_s2_vld;
    logic [15:0] r_s2_gain;
    logic [31:0] r_s2_p;
    logic        r_s3_vld;
    logic [15:0] r_s3_gain;
    logic signed [17:0] r_s3_wave;

    logic        r_out_vld;
    logic [15:0] r_out;
    logic        w_out_load;
    logic        w_div_start, w_div_done;
    logic [54:0] w_quo;

    logic [15:0] w_gain, w_phase, w_freq;
    logic [39:0] w_total;
    logic [55:0] w_prod;
    logic [31:0] w_p;
    logic signed [17:0] w_wave;
    logic signed [34:0] w_gw;
    logic [15:0] w_lfsr_next;
    logic [SW+1:0] w_sidx;
    logic [SW-1:0] w_off;
    logic [SW:0]   w_tidx;
    logic [15:0]   w_sine;
    logic signed [55:0] w_sum;

    logic [15:0] c_sine [SINE_TABLE_DEPTH+1];
    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_sine
        localparam logic [15:0] SINE_VAL = quarter_sine(g);
        assign c_sine[g] = SINE_VAL;
    end

    assign w_count = ({1'b0, r_osc_count} > 7'(MAX_OSCILLATORS)) ? 7'(MAX_OSCILLATORS)
                                                                  : {1'b0, r_osc_count};

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_inc  <= BASE_INC_RESET;
            r_cycle_len <= CYCLE_LEN_RESET;
            r_shape     <= SHAPE_SINE;
            r_osc_count <= 6'd1;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                REG_BASE_INC:  r_base_inc  <= i_cfg.data.value;
                REG_CYCLE_LEN: r_cycle_len <= i_cfg.data.value[19:0];
                REG_SHAPE:     r_shape     <= i_cfg.data.value[2:0];
                REG_OSC_COUNT: r_osc_count <= i_cfg.data.value[5:0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_out_load = (r_state == ST_OUT) && (!r_out_vld || o_out.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in.valid && i_in.ready && i_in.data.operation == OP_AUDIO)
                          n_state = ST_SCAN;
            ST_SCAN:  if (r_idx >= w_count) n_state = ST_DRAIN;
            ST_DRAIN: if (!r_rd_vld && !r_s2_vld && !r_s3_vld) n_state = ST_DIV;
            ST_DIV:   if (w_div_done) n_state = ST_OUT;
            ST_OUT:   if (!r_out_vld || o_out.ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    assign w_div_start = (r_state == ST_DRAIN) && (n_state == ST_DIV);

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready && i_in.data.operation == OP_WRITE &&
            (32'(i_in.data.osc_index) < 32'(MAX_OSCILLATORS))) begin
            r_mem[IW'(i_in.data.osc_index)] <= {i_in.data.osc_gain, i_in.data.osc_phase,
                                                i_in.data.osc_freq_factor};
        end
        r_rd     <= r_mem[IW'(r_idx)];
        r_rd_idx <= IW'(r_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_in.valid && i_in.ready && i_in.data.operation == OP_WRITE &&
                     (32'(i_in.data.osc_index) < 32'(MAX_OSCILLATORS))) begin
            r_written[IW'(i_in.data.osc_index)] <= 1'b1;
        end
    end

    always_comb begin
        if (r_written[r_rd_idx]) begin
            {w_gain, w_phase, w_freq} = r_rd;
        end else begin
            w_gain  = (r_rd_idx == '0) ? GAIN_FULL : 16'd0;
            w_phase = '0;
            w_freq  = FREQ_ONE;
        end
    end

    assign w_total = r_tb[39:0] + {8'd0, w_phase, 16'd0};
    assign w_prod  = w_total * w_freq;
    assign w_p     = w_prod[39:8];

    assign w_lfsr_next = r_lfsr[0] ? ((r_lfsr >> 1) ^ LFSR_TAPS) : (r_lfsr >> 1);
    assign w_sidx = r_s2_p[31 -: SW+2];
    assign w_off  = w_sidx[SW-1:0];
    assign w_tidx = w_sidx[SW] ? ((SW+1)'(SINE_TABLE_DEPTH) - {1'b0, w_off}) : {1'b0, w_off};
    assign w_sine = c_sine[w_tidx];

    always_comb begin
        case (r_shape)
            SHAPE_SINE:     w_wave = w_sidx[SW+1] ? -$signed({2'b00, w_sine})
                                                  : $signed({2'b00, w_sine});
            SHAPE_SAW:      w_wave = 18'sd32768 - $signed({2'b00, r_s2_p[31:16]});
            SHAPE_SQUARE:   w_wave = r_s2_p[31] ? 18'sd32768 : -18'sd32768;
            SHAPE_TRIANGLE: w_wave = r_s2_p[31] ?
                                     $signed({1'b0, r_s2_p[31:15]}) - 18'sd98304 :
                                     18'sd32768 - $signed({1'b0, r_s2_p[31:15]});
            SHAPE_PULSE:    w_wave = r_s2_p[31] ? 18'sd32768 : 18'sd0;
            SHAPE_NOISE:    w_wave = $signed({2'b00, w_lfsr_next}) - 18'sd32768;
            default:        w_wave = '0;
        endcase
    end

    assign w_gw  = $signed({1'b0, r_s3_gain}) * r_s3_wave;
    assign w_sum = $signed({{17{r_audio[15]}}, r_audio, 23'd0}) >>> 23;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_time    <= '0;
            r_lfsr    <= LFSR_SEED;
            r_rd_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_tb_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_out.valid && o_out.ready) r_out_vld <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    r_idx    <= '0;
                    r_tb_vld <= 1'b0;
                    if (n_state == ST_SCAN) begin
                        r_audio    <= i_in.data.audio_in;
                        r_gain_tot <= '0;
                        r_tb       <= 52'(r_time) * 52'(r_base_inc);
                    end
                end
                ST_SCAN: begin
                    r_tb_vld <= 1'b1;
                    if (r_tb_vld && r_idx < w_count) r_idx <= r_idx + 7'd1;
                end
                ST_OUT: begin
                    if (w_out_load) begin
                        r_out_vld <= 1'b1;
                        r_time <= (r_time + 20'd1 >= r_cycle_len) ? 20'd0 : r_time + 20'd1;
                    end
                end
                default: ;
            endcase
            r_rd_vld <= (r_state == ST_SCAN) && r_tb_vld && (r_idx < w_count);
            r_s2_vld <= r_rd_vld && (w_gain != '0);
            r_s3_vld <= r_s2_vld;
            if (r_rd_vld) r_gain_tot <= r_gain_tot + 22'(w_gain);
            if (r_s2_vld && r_shape == SHAPE_NOISE) r_lfsr <= w_lfsr_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_s2_gain <= w_gain;
            r_s2_p    <= w_p;
        end
        if (r_s2_vld) begin
            r_s3_gain <= r_s2_gain;
            r_s3_wave <= w_wave;
        end
        if (r_state == ST_IDLE && n_state == ST_SCAN) begin
            r_acc <= '0;
        end else if (r_s3_vld) begin
            r_acc <= r_acc + {{20{w_gw[34]}}, w_gw};
        end
        if (w_out_load) begin
            if ($signed(w_quo) + w_sum > 56'sd32767)       r_out <= 16'h7FFF;
            else if ($signed(w_quo) + w_sum < -56'sd32768) r_out <= 16'h8000;
            else r_out <= 16'($signed(w_quo) + w_sum);
        end
    end

    aob_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_acc),
        .i_divisor  (r_gain_tot),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;
endmodule

// ===== src/aob_divider.sv =====
//==============================================================================
// aob_divider
// Signed by unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero.
//==============================================================================
module aob_divider
    import aob_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [54:0] i_dividend,
    input  logic [21:0] i_divisor,
    output logic        o_done,
    output logic [54:0] o_quotient
);
    logic [5:0]  r_count;
    logic        r_busy;
    logic        r_neg;
    logic [53:0] r_num;
    logic [53:0] r_quo;
    logic [22:0] r_rem;
    logic [21:0] r_div;
    logic [22:0] w_try;
    logic [22:0] w_sub;

    assign w_try = {r_rem[21:0], r_num[53]};
    assign w_sub = w_try - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= 6'd54;
                r_neg   <= i_dividend[54];
                r_num   <= i_dividend[54] ? 54'(-i_dividend) : i_dividend[53:0];
                r_div   <= (i_divisor == '0) ? 22'd1 : i_divisor;
                r_rem   <= '0;
                r_quo   <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[52:0], 1'b0};
                if (!w_sub[22]) begin
                    r_rem <= w_sub;
                    r_quo <= {r_quo[52:0], 1'b1};
                end else begin
                    r_rem <= w_try;
                    r_quo <= {r_quo[52:0], 1'b0};
                end
                r_count <= r_count - 6'd1;
                if (r_count == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient = r_neg ? -{1'b0, r_quo} : {1'b0, r_quo};
endmodule

// ===== src/aob_checker.sv =====
//==============================================================================
// aob_checker
// Port-level checks for the oscillator bank.
//==============================================================================
module aob_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("Output changed while stalled.");
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |=> i_in_valid)
        else $error("Input valid dropped before its transfer.");
    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !$isunknown(i_out_data))
        else $error("Output data unknown while valid.");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Output valid after reset.");
endmodule

bind additive_oscillator_bank_unit aob_checker u_aob_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
//==============================================================================
// tb_top
// Checks the oscillator bank against a cycle-free model of its arithmetic:
// table writes and audio samples are sent in bursts under several register
// settings, and every output sample is compared with the predicted mix.
//==============================================================================
module tb_top;
    import aob_pkg::*;

    localparam int OSC_MAX    = 32;
    localparam int SINE_DEPTH = SINE_TABLE_DEPTH;

    typedef longint unsigned t_u64;

    logic i_clk;
    logic i_rst_n;

    aob_stream_if #(.T(t_in_item))  in_if ();
    aob_stream_if #(.T(t_cfg_item)) cfg_if ();
    aob_stream_if #(.T(t_sample))   out_if ();

    additive_oscillator_bank_unit #(
        .MAX_OSCILLATORS (OSC_MAX)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .i_cfg  (cfg_if.sink),
        .o_out  (out_if.source)
    );

    // Model state.
    logic [15:0] tbl_gain [OSC_MAX];
    logic [15:0] tbl_phase[OSC_MAX];
    logic [15:0] tbl_freq [OSC_MAX];
    logic [21:0] sum_gain;
    logic [19:0] sample_count;
    logic [15:0] lfsr;
    logic [31:0] m_base;
    logic [19:0] m_cycle;
    logic [2:0]  m_shape;
    logic [5:0]  m_count;
    int          sine_mag[SINE_DEPTH + 1];

    t_in_item   pending_items[$];
    t_sample    expected_samples[$];
    int         fail_count;
    bit         hold_sender;
    int         burst_left;
    int         gap_left;
    int         ready_mode;
    int         ready_timer;

    function automatic int series_sine(int k);
        longint unsigned x, x2, term;
        longint          acc;
        x = (longint'(k) * 64'd1686629713) / SINE_DEPTH;
        x2 = (x * x) >> 30;
        term = x;
        acc = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        return int'((t_u64'(acc) * 32767 + (64'd1 << 29)) >> 30);
    endfunction

    function automatic int wave_of(logic [31:0] p, logic [2:0] shape);
        longint unsigned idx;
        int q, off, v;
        case (shape)
            SHAPE_SINE: begin
                idx = (t_u64'(p) * (4 * SINE_DEPTH)) >> 32;
                q = int'(idx / SINE_DEPTH);
                off = int'(idx % SINE_DEPTH);
                v = (q % 2 == 1) ? sine_mag[SINE_DEPTH - off] : sine_mag[off];
                return (q & 2) ? -v : v;
            end
            SHAPE_SAW:      return 32768 - int'(p >> 16);
            SHAPE_SQUARE:   return p[31] ? 32768 : -32768;
            SHAPE_TRIANGLE: return p[31] ? int'(p >> 15) - 98304 : 32768 - int'(p >> 15);
            SHAPE_PULSE:    return p[31] ? 32768 : 0;
            SHAPE_NOISE: begin
                lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
                return int'(lfsr) - 32768;
            end
            default: return 0;
        endcase
    endfunction

    function automatic void predict_mix(t_in_item it);
        int              n;
        longint          acc, mix, s;
        longint unsigned tot, prod;
        logic [31:0]     p;
        logic [19:0]     t;
        if (it.operation == OP_WRITE) begin
            tbl_gain[it.osc_index] = it.osc_gain;
            tbl_phase[it.osc_index] = it.osc_phase;
            tbl_freq[it.osc_index] = it.osc_freq_factor;
            return;
        end
        n = (m_count > OSC_MAX) ? OSC_MAX : int'(m_count);
        t = sample_count;
        acc = 0;
        sum_gain = 0;
        for (int i = 0; i < n; i++) begin
            sum_gain += tbl_gain[i];
            if (tbl_gain[i] != 0) begin
                tot = t_u64'(t) * m_base + (t_u64'(tbl_phase[i]) << 16);
                prod = tot * tbl_freq[i];
                p = prod[39:8];
                acc += longint'(tbl_gain[i]) * longint'(wave_of(p, m_shape));
            end
        end
        mix = acc / ((sum_gain == 0) ? 64'sd1 : longint'(sum_gain));
        s = longint'(it.audio_in) + mix;
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        expected_samples.push_back(t_sample'(s));
        t = t + 1;
        sample_count = (t >= m_cycle) ? 20'd0 : t;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) predict_mix(in_if.data);
            if (in_if.valid && !in_if.ready) begin
                in_if.valid <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_if.valid <= 1'b0;
            end else if (!hold_sender && pending_items.size() > 0) begin
                in_if.data <= pending_items.pop_front();
                in_if.valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern switches among four ready modes, each held for a random time.
    always @(posedge i_clk) begin
        if (ready_timer == 0) begin
            ready_mode <= $urandom_range(0, 3);
            ready_timer <= $urandom_range(50, 500);
        end else begin
            ready_timer <= ready_timer - 1;
        end
        case (ready_mode)
            0:       out_if.ready <= 1'b1;
            1:       out_if.ready <= ($urandom_range(0, 3) != 0);
            2:       out_if.ready <= ($urandom_range(0, 3) == 0);
            default: out_if.ready <= ($urandom_range(0, 15) == 0);
        endcase
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_samples.size() == 0) begin
                $error("audio_out transfer with nothing expected: actual %0d", out_if.data);
                fail_count++;
            end else begin
                if (out_if.data !== expected_samples[0]) begin
                    $error("audio_out mismatch: expected %0d, actual %0d",
                           expected_samples[0], out_if.data);
                    fail_count++;
                end
                void'(expected_samples.pop_front());
            end
        end
    end

    task automatic write_reg(t_reg_index index, logic [31:0] value);
        @(posedge i_clk);
        cfg_if.data <= '{index: index, value: value};
        cfg_if.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        case (index)
            REG_BASE_INC:  m_base = value;
            REG_CYCLE_LEN: m_cycle = value[19:0];
            REG_SHAPE:     m_shape = value[2:0];
            REG_OSC_COUNT: m_count = value[5:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_items.size() != 0 || in_if.valid || expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [31:0] base, logic [19:0] cyc, logic [2:0] shape,
                            logic [5:0] cnt);
        write_reg(REG_BASE_INC, base);
        write_reg(REG_CYCLE_LEN, {12'd0, cyc});
        write_reg(REG_SHAPE, {29'd0, shape});
        write_reg(REG_OSC_COUNT, {26'd0, cnt});
    endtask

    function automatic t_in_item audio_item(logic signed [15:0] a);
        return '{operation: OP_AUDIO, audio_in: a, osc_index: '0, osc_gain: '0,
                 osc_phase: '0, osc_freq_factor: '0};
    endfunction

    function automatic t_in_item table_item(logic [4:0] i, logic [15:0] g, logic [15:0] ph,
                                            logic [15:0] f);
        return '{operation: OP_WRITE, audio_in: 16'($urandom), osc_index: i, osc_gain: g,
                 osc_phase: ph, osc_freq_factor: f};
    endfunction

    function automatic t_in_item random_item();
        logic [15:0] g;
        if ($urandom_range(0, 4) != 0) return audio_item(16'($urandom));
        g = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
        return table_item(5'($urandom), g, 16'($urandom), 16'($urandom));
    endfunction

    initial begin
        logic [31:0] base;
        logic [19:0] cyc;
        logic [5:0]  cnt;
        int          nitems;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        out_if.ready = 1'b0;
        fail_count = 0;
        hold_sender = 1'b0;
        burst_left = 0;
        gap_left = 0;
        ready_mode = 0;
        ready_timer = 0;
        for (int k = 0; k <= SINE_DEPTH; k++) sine_mag[k] = series_sine(k);
        for (int i = 0; i < OSC_MAX; i++) begin
            tbl_gain[i] = (i == 0) ? GAIN_FULL : 16'd0;
            tbl_phase[i] = '0;
            tbl_freq[i] = FREQ_ONE;
        end
        sum_gain = 22'd65535;
        sample_count = '0;
        lfsr = LFSR_SEED;
        m_base = BASE_INC_RESET;
        m_cycle = CYCLE_LEN_RESET;
        m_shape = SHAPE_SINE;
        m_count = 6'd1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: field extremes at reset settings, then every shape.
        pending_items.push_back(audio_item(16'sh7FFF));
        pending_items.push_back(audio_item(16'sh8000));
        pending_items.push_back(table_item(5'd0, 16'd0, 16'd0, 16'd256));
        pending_items.push_back(audio_item(16'sd1234));
        pending_items.push_back(table_item(5'd31, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pending_items.push_back(table_item(5'd1, 16'h8000, 16'h4000, 16'd0));
        pending_items.push_back(table_item(5'd0, 16'hFFFF, 16'd0, 16'd1));
        pending_items.push_back(audio_item(16'sd0));
        wait_drained();
        for (int s = 0; s < 8; s++) begin
            set_regs(s[0] ? 32'hFFFF_FFFF : 32'h0123_4567, s[1] ? 20'd0 : 20'd3, s[2:0],
                     (s == 3) ? 6'd0 : (s == 4) ? 6'd63 : 6'd32);
            pending_items.push_back(audio_item(16'sh7FFF));
            pending_items.push_back(audio_item(16'sh8000));
            wait_drained();
        end

        // Random part.
        for (int ph = 0; ph < 12; ph++) begin
            case ($urandom_range(0, 3))
                0:       base = 32'd0;
                1:       base = 32'hFFFF_FFFF;
                default: base = $urandom;
            endcase
            case ($urandom_range(0, 4))
                0:       cyc = 20'd0;
                1:       cyc = 20'hFFFFF;
                2:       cyc = 20'd1;
                default: cyc = 20'($urandom_range(2, 60));
            endcase
            case ($urandom_range(0, 3))
                0:       cnt = 6'd32;
                1:       cnt = 6'($urandom_range(33, 63));
                default: cnt = 6'($urandom_range(0, 31));
            endcase
            set_regs(base, cyc, (ph < 6) ? 3'(ph) : 3'($urandom_range(0, 7)), cnt);
            nitems = $urandom_range(100, 150);
            for (int n = 0; n < nitems; n++) pending_items.push_back(random_item());
            if (ph == 5) begin
                while (pending_items.size() > nitems / 2) @(posedge i_clk);
                hold_sender = 1'b1;
                @(posedge i_clk);
                while (in_if.valid || expected_samples.size() != 0) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            wait_drained();
        end

        repeat (50) @(posedge i_clk);
        if (expected_samples.size() != 0) begin
            $error("audio_out: %0d expected samples never arrived", expected_samples.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/aob_pkg.sv
src/aob_if.sv
src/aob_divider.sv
src/additive_oscillator_bank_unit.sv
src/aob_checker.sv
test/tb_top.sv
